[rtl/ydl_pkg.sv]
// shared constants for the yadif line deinterlacer
package ydl_pkg;

  // default sizes
  localparam int unsigned SAMPLE_BITS_DEF = 8;
  localparam int unsigned MAX_WIDTH_DEF   = 4096;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LW_W       = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd1;

  localparam logic [MODE_W-1:0] MODE_RESET       = 2'd0;
  localparam logic [LW_W-1:0]   LW_RESET         = 13'd1920;
  // modes below this one run the extra spatial-temporal check
  localparam logic [MODE_W-1:0] MODE_EXTRA_LIMIT = 2'd2;

  // window geometry
  localparam int unsigned WIN      = 7;
  localparam int unsigned CTR      = 3;
  localparam int unsigned DLY      = 3;
  localparam int unsigned PAD_COLS = 3;

  // temporal pair sample slots
  localparam int unsigned PAIR_N         = 6;
  localparam int unsigned PR_EARLY_CTR   = 0;
  localparam int unsigned PR_LATE_CTR    = 1;
  localparam int unsigned PR_EARLY_UP2   = 2;
  localparam int unsigned PR_LATE_UP2    = 3;
  localparam int unsigned PR_EARLY_DOWN2 = 4;
  localparam int unsigned PR_LATE_DOWN2  = 5;

  // prev/next frame sample slots
  localparam int unsigned NBR_N         = 4;
  localparam int unsigned NB_PREV_ABOVE = 0;
  localparam int unsigned NB_PREV_BELOW = 1;
  localparam int unsigned NB_NEXT_ABOVE = 2;
  localparam int unsigned NB_NEXT_BELOW = 3;

endpackage

[rtl/ydl_in_if.sv]
// column input channel of the deinterlacer
interface ydl_in_if #(
  parameter int unsigned SAMPLE_BITS = ydl_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] cur_above;
  logic [SAMPLE_BITS-1:0] cur_below;
  logic [SAMPLE_BITS-1:0] prev_above;
  logic [SAMPLE_BITS-1:0] prev_below;
  logic [SAMPLE_BITS-1:0] next_above;
  logic [SAMPLE_BITS-1:0] next_below;
  logic [SAMPLE_BITS-1:0] early_centre;
  logic [SAMPLE_BITS-1:0] late_centre;
  logic [SAMPLE_BITS-1:0] early_up_two;
  logic [SAMPLE_BITS-1:0] late_up_two;
  logic [SAMPLE_BITS-1:0] early_down_two;
  logic [SAMPLE_BITS-1:0] late_down_two;

  modport source (
    output valid, cur_above, cur_below, prev_above, prev_below, next_above, next_below,
           early_centre, late_centre, early_up_two, late_up_two, early_down_two,
           late_down_two,
    input  ready
  );
  modport sink (
    input  valid, cur_above, cur_below, prev_above, prev_below, next_above, next_below,
           early_centre, late_centre, early_up_two, late_up_two, early_down_two,
           late_down_two,
    output ready
  );
endinterface

[rtl/ydl_out_if.sv]
// pixel output channel of the deinterlacer
interface ydl_out_if #(
  parameter int unsigned SAMPLE_BITS = ydl_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pixel_out;
  logic                   line_end;

  modport source (output valid, pixel_out, line_end, input ready);
  modport sink (input valid, pixel_out, line_end, output ready);
endinterface

[rtl/ydl_pixel.sv]
// yadif pixel rule: spatial edge search, temporal clamp
module ydl_pixel #(
  parameter int unsigned SAMPLE_BITS = ydl_pkg::SAMPLE_BITS_DEF
) (
  input  logic [ydl_pkg::WIN-1:0][SAMPLE_BITS-1:0]    upper_i,
  input  logic [ydl_pkg::WIN-1:0][SAMPLE_BITS-1:0]    lower_i,
  input  logic [ydl_pkg::PAIR_N-1:0][SAMPLE_BITS-1:0] pair_i,
  input  logic [ydl_pkg::NBR_N-1:0][SAMPLE_BITS-1:0]  nbr_i,
  input  logic                                        extra_check_i,
  output logic [SAMPLE_BITS-1:0]                      pixel_o
);

  localparam int unsigned SW = SAMPLE_BITS + 4;
  typedef logic signed [SW-1:0] val_t;

  function automatic val_t ext(input logic [SAMPLE_BITS-1:0] v);
    return $signed({{(SW-SAMPLE_BITS){1'b0}}, v});
  endfunction

  function automatic val_t absd(input logic [SAMPLE_BITS-1:0] a,
                                input logic [SAMPLE_BITS-1:0] b);
    val_t t;
    t = ext(a) - ext(b);
    return (t < 0) ? -t : t;
  endfunction

  function automatic val_t avg(input logic [SAMPLE_BITS-1:0] a,
                               input logic [SAMPLE_BITS-1:0] b);
    return (ext(a) + ext(b)) >>> 1;
  endfunction

  function automatic val_t smax(input val_t a, input val_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic val_t smin(input val_t a, input val_t b);
    return (a < b) ? a : b;
  endfunction

  val_t c, e, d, b2, f2;
  val_t td0, td1, td2, diff_t, hi, lo, diff;
  val_t s_m2, s_m1, s_0, s_p1, s_p2;
  val_t p_m2, p_m1, p_0, p_p1, p_p2;
  val_t best1, pred1, best2, pred2, res;

  // direction scores and predictions, all independent
  always_comb begin
    s_0  = absd(upper_i[2], lower_i[2]) + absd(upper_i[3], lower_i[3])
         + absd(upper_i[4], lower_i[4]);
    s_m1 = absd(upper_i[1], lower_i[3]) + absd(upper_i[2], lower_i[4])
         + absd(upper_i[3], lower_i[5]);
    s_m2 = absd(upper_i[0], lower_i[4]) + absd(upper_i[1], lower_i[5])
         + absd(upper_i[2], lower_i[6]);
    s_p1 = absd(upper_i[3], lower_i[1]) + absd(upper_i[4], lower_i[2])
         + absd(upper_i[5], lower_i[3]);
    s_p2 = absd(upper_i[4], lower_i[0]) + absd(upper_i[5], lower_i[1])
         + absd(upper_i[6], lower_i[2]);
    p_0  = avg(upper_i[3], lower_i[3]);
    p_m1 = avg(upper_i[2], lower_i[4]);
    p_m2 = avg(upper_i[1], lower_i[5]);
    p_p1 = avg(upper_i[4], lower_i[2]);
    p_p2 = avg(upper_i[5], lower_i[1]);
  end

  // edge search: the outer direction is tried only if the inner one won
  always_comb begin
    if (s_m1 < s_0 - val_t'(1)) begin
      best1 = (s_m2 < s_m1) ? s_m2 : s_m1;
      pred1 = (s_m2 < s_m1) ? p_m2 : p_m1;
    end else begin
      best1 = s_0 - val_t'(1);
      pred1 = p_0;
    end
    if (s_p1 < best1) begin
      best2 = (s_p2 < s_p1) ? s_p2 : s_p1;
      pred2 = (s_p2 < s_p1) ? p_p2 : p_p1;
    end else begin
      best2 = best1;
      pred2 = pred1;
    end
  end

  // temporal change and clamp
  always_comb begin
    c   = ext(upper_i[ydl_pkg::CTR]);
    e   = ext(lower_i[ydl_pkg::CTR]);
    d   = avg(pair_i[ydl_pkg::PR_EARLY_CTR], pair_i[ydl_pkg::PR_LATE_CTR]);
    b2  = avg(pair_i[ydl_pkg::PR_EARLY_UP2], pair_i[ydl_pkg::PR_LATE_UP2]);
    f2  = avg(pair_i[ydl_pkg::PR_EARLY_DOWN2], pair_i[ydl_pkg::PR_LATE_DOWN2]);
    td0 = absd(pair_i[ydl_pkg::PR_EARLY_CTR], pair_i[ydl_pkg::PR_LATE_CTR]);
    td1 = (absd(nbr_i[ydl_pkg::NB_PREV_ABOVE], upper_i[ydl_pkg::CTR])
         + absd(nbr_i[ydl_pkg::NB_PREV_BELOW], lower_i[ydl_pkg::CTR])) >>> 1;
    td2 = (absd(nbr_i[ydl_pkg::NB_NEXT_ABOVE], upper_i[ydl_pkg::CTR])
         + absd(nbr_i[ydl_pkg::NB_NEXT_BELOW], lower_i[ydl_pkg::CTR])) >>> 1;
    diff_t = smax(smax(td0 >>> 1, td1), td2);
    hi = smax(smax(d - e, d - c), smin(b2 - c, f2 - e));
    lo = smin(smin(d - e, d - c), smax(b2 - c, f2 - e));
    diff = extra_check_i ? smax(smax(diff_t, lo), -hi) : diff_t;
    if (pred2 > d + diff) begin
      res = d + diff;
    end else if (pred2 < d - diff) begin
      res = d - diff;
    end else begin
      res = pred2;
    end
    pixel_o = res[SAMPLE_BITS-1:0];
  end

endmodule

[rtl/yadif_deinterlace_line.sv]
// yadif line deinterlacer top level: column window, line counter, result register
//
//   port        dir  kind             payload
//   in_i        in   valid/ready      twelve neighbourhood samples of one column
//   out_o       out  valid/ready      pixel_out, line_end
//   cfg_*_i     in   write enable     filter_mode (index 0), line_width (index 1)
//
// one column is taken per clock unless a result waits behind a stalled output
// the window shift registers load the column, then the pixel rule runs between them and
// the result register
// each line carries line_width + 6 columns; the first six give no result
// reset clears the counter and the valid flags and loads the configuration defaults; no clearing pass
// a stalled output holds the result; one more column that owes a result is taken behind it
module yadif_deinterlace_line #(
  parameter int unsigned SAMPLE_BITS = ydl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_WIDTH   = ydl_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ydl_in_if.sink                           in_i,
  ydl_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [ydl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ydl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned WIN    = ydl_pkg::WIN;
  localparam int unsigned DLY    = ydl_pkg::DLY;
  localparam int unsigned PAIR_N = ydl_pkg::PAIR_N;
  localparam int unsigned NBR_N  = ydl_pkg::NBR_N;
  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH + 2 * ydl_pkg::PAD_COLS);
  localparam int unsigned CMP_W  = ((CNT_W > ydl_pkg::LW_W) ? CNT_W : ydl_pkg::LW_W) + 1;

  // configuration
  logic [ydl_pkg::MODE_W-1:0] mode_q;
  logic [ydl_pkg::LW_W-1:0]   width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ydl_pkg::MODE_RESET;
      width_q <= ydl_pkg::LW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ydl_pkg::REG_FILTER_MODE: mode_q  <= cfg_data_i[ydl_pkg::MODE_W-1:0];
        ydl_pkg::REG_LINE_WIDTH:  width_q <= cfg_data_i[ydl_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline flags
  logic s1_q, s1_d;          // window holds a column that owes a result
  logic s1_end_q, s1_end_d;
  logic out_vld_q, out_vld_d;
  logic out_free, accept;

  assign out_free   = !out_vld_q || out_o.ready;
  assign in_i.ready = !s1_q || out_free;
  assign accept     = in_i.valid && in_i.ready;

  // column counter; line_width saturates at the widest line
  logic [CNT_W-1:0] cc_q, cc_d;
  logic [CMP_W-1:0] lw_ext, w_sat, last_col, cc_ext;
  logic             emit, wrap;

  always_comb begin
    lw_ext   = CMP_W'(width_q);
    w_sat    = (lw_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : lw_ext;
    last_col = w_sat + CMP_W'(2 * ydl_pkg::PAD_COLS - 1);
    cc_ext   = CMP_W'(cc_q);
    emit     = (cc_ext >= CMP_W'(2 * ydl_pkg::PAD_COLS)) && (cc_ext <= last_col);
    wrap     = cc_ext >= last_col;
    cc_d     = wrap ? '0 : cc_q + CNT_W'(1);
  end

  always_comb begin
    s1_d     = s1_q;
    s1_end_d = s1_end_q;
    if (accept) begin
      s1_d     = emit;
      s1_end_d = (cc_ext == last_col);
    end else if (out_free) begin
      s1_d = 1'b0;
    end
    out_vld_d = out_free ? s1_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q      <= '0;
      s1_q      <= 1'b0;
      s1_end_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        cc_q <= cc_d;
      end
      s1_q      <= s1_d;
      s1_end_q  <= s1_end_d;
      out_vld_q <= out_vld_d;
    end
  end

  // window and delay lines; the delay keeps one extra column so that the
  // pair used by the pixel rule lines up with the window centre after the shift
  logic [WIN-1:0][SAMPLE_BITS-1:0]    upper_q, lower_q;
  logic [PAIR_N-1:0][SAMPLE_BITS-1:0] pair_q [DLY+1];
  logic [NBR_N-1:0][SAMPLE_BITS-1:0]  nbr_q  [DLY+1];
  logic [PAIR_N-1:0][SAMPLE_BITS-1:0] pair_new;
  logic [NBR_N-1:0][SAMPLE_BITS-1:0]  nbr_new;

  always_comb begin
    pair_new[ydl_pkg::PR_EARLY_CTR]   = in_i.early_centre;
    pair_new[ydl_pkg::PR_LATE_CTR]    = in_i.late_centre;
    pair_new[ydl_pkg::PR_EARLY_UP2]   = in_i.early_up_two;
    pair_new[ydl_pkg::PR_LATE_UP2]    = in_i.late_up_two;
    pair_new[ydl_pkg::PR_EARLY_DOWN2] = in_i.early_down_two;
    pair_new[ydl_pkg::PR_LATE_DOWN2]  = in_i.late_down_two;
    nbr_new[ydl_pkg::NB_PREV_ABOVE]   = in_i.prev_above;
    nbr_new[ydl_pkg::NB_PREV_BELOW]   = in_i.prev_below;
    nbr_new[ydl_pkg::NB_NEXT_ABOVE]   = in_i.next_above;
    nbr_new[ydl_pkg::NB_NEXT_BELOW]   = in_i.next_below;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_q  <= {in_i.cur_above, upper_q[WIN-1:1]};
      lower_q  <= {in_i.cur_below, lower_q[WIN-1:1]};
      pair_q[0] <= pair_new;
      nbr_q[0]  <= nbr_new;
      for (int i = 1; i <= DLY; i++) begin
        pair_q[i] <= pair_q[i-1];
        nbr_q[i]  <= nbr_q[i-1];
      end
    end
  end

  // pixel rule between the window registers and the result register
  logic [SAMPLE_BITS-1:0] pixel_d, pixel_q;
  logic                   line_end_q;

  ydl_pixel #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pixel (
    .upper_i       (upper_q),
    .lower_i       (lower_q),
    .pair_i        (pair_q[DLY]),
    .nbr_i         (nbr_q[DLY]),
    .extra_check_i (mode_q < ydl_pkg::MODE_EXTRA_LIMIT),
    .pixel_o       (pixel_d)
  );

  always_ff @(posedge clk_i) begin
    if (out_free && s1_q) begin
      pixel_q    <= pixel_d;
      line_end_q <= s1_end_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.pixel_out = pixel_q;
  assign out_o.line_end  = line_end_q;

  // counter never runs past the last column of the widest line
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(cc_q) <= CMP_W'(MAX_WIDTH + 2 * ydl_pkg::PAD_COLS - 1))
    else $error("column counter out of range");

  // the last column of a line restarts the count
  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cc_ext == last_col) |=> (cc_q == '0))
    else $error("counter did not restart at line end");

  // a column inside the line leaves a pending result
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |=> s1_q)
    else $error("result of an active column lost");

  // a pending result moves to the output when it is free
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q && out_free |=> out_vld_q)
    else $error("pending result not moved to output");

  // a column is never taken over a pending result that cannot move
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q && !out_free |=> $stable(upper_q) && $stable(lower_q))
    else $error("window shifted under a pending result");

endmodule
